### rtl/dhlm_pkg.sv
package dhlm_pkg;

    localparam int MAX_HUNKS_DEF = 64;
    localparam int LINE_BITS_DEF = 32;
    localparam int FIELD_W       = 32;
    localparam int OUT_W         = 32;

    // opcode field values
    localparam logic [1:0] OPC_APPEND = 2'd0;
    localparam logic [1:0] OPC_CLEAR  = 2'd1;
    localparam logic [1:0] OPC_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_CLEAR,
        OP_QUERY,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] left_start;
        logic [FIELD_W-1:0] left_count;
        logic [FIELD_W-1:0] right_start;
        logic [FIELD_W-1:0] right_count;
        logic [FIELD_W-1:0] source_line;
        logic               left_to_right;
    } item_t;

endpackage

### rtl/dhlm_ram.sv
module dhlm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/dhlm_front.sv
module dhlm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic [dhlm_pkg::FIELD_W-1:0] left_start,
    input  logic [dhlm_pkg::FIELD_W-1:0] left_count,
    input  logic [dhlm_pkg::FIELD_W-1:0] right_start,
    input  logic [dhlm_pkg::FIELD_W-1:0] right_count,
    input  logic [dhlm_pkg::FIELD_W-1:0] source_line,
    input  logic                      left_to_right,
    output logic                      head_valid,
    output dhlm_pkg::item_t           head,
    input  logic                      pop
);

    // two-word queue toward the executor
    dhlm_pkg::item_t q_mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push;
    dhlm_pkg::op_t   op_dec;
    dhlm_pkg::item_t word;

    always_comb
    begin
        unique case (opcode)
            dhlm_pkg::OPC_APPEND: op_dec = dhlm_pkg::OP_APPEND;
            dhlm_pkg::OPC_CLEAR:  op_dec = dhlm_pkg::OP_CLEAR;
            dhlm_pkg::OPC_QUERY:  op_dec = dhlm_pkg::OP_QUERY;
            default:              op_dec = dhlm_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        word.op            = op_dec;
        word.left_start    = left_start;
        word.left_count    = left_count;
        word.right_start   = right_start;
        word.right_count   = right_count;
        word.source_line   = source_line;
        word.left_to_right = left_to_right;
    end

    assign busy       = (cnt_reg == 2'd2);
    assign push       = start && !busy;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= word;
        end
    end

endmodule

### rtl/dhlm_back.sv
module dhlm_back #(
    parameter int MAX_HUNKS = dhlm_pkg::MAX_HUNKS_DEF,
    parameter int LINE_BITS = dhlm_pkg::LINE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  dhlm_pkg::item_t            head,
    output logic                       pop,
    output logic [dhlm_pkg::OUT_W-1:0] mapped_line,
    output logic [1:0]                 status,
    output logic                       done
);

    localparam int LB    = LINE_BITS;
    localparam int IDX_W = $clog2(MAX_HUNKS);
    localparam int CNT_W = $clog2(MAX_HUNKS + 1);
    localparam int HW    = 4 * LB;
    localparam logic [LB-1:0] LINE_MAX = {LB{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_REL,
        S_SUM
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LB-1:0]      line_reg, line_next;
    logic               dir_reg, dir_next;
    logic [LB:0]        offset_reg, offset_next;   // two's complement
    logic [LB-1:0]      base_reg, base_next;
    logic [LB:0]        addend_reg, addend_next;   // two's complement
    logic [LB-1:0]      ss_reg, ss_next;
    logic [LB-1:0]      tc_reg, tc_next;
    logic [dhlm_pkg::OUT_W-1:0] mapped_reg, mapped_next;
    logic [1:0]         status_reg, status_next;
    logic               done_reg, done_next;

    logic               we;
    logic [IDX_W-1:0]   raddr;
    logic [HW-1:0]      wdata, rdata;

    logic [LB-1:0]      h_ls, h_lc, h_rs, h_rc;
    logic [LB-1:0]      ss, sc, ts, tc;
    logic [LB:0]        send_raw, tend_raw;
    logic [LB-1:0]      send, tend;
    logic               below_start, in_range, last_hunk;
    logic [LB-1:0]      diff, lim, rel;
    logic [LB+1:0]      sum;

    dhlm_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_HUNKS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (total_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign wdata = {LB'(head.left_start), LB'(head.left_count),
                    LB'(head.right_start), LB'(head.right_count)};

    assign h_ls = rdata[4*LB-1:3*LB];
    assign h_lc = rdata[3*LB-1:2*LB];
    assign h_rs = rdata[2*LB-1:LB];
    assign h_rc = rdata[LB-1:0];

    // orient the hunk by direction
    assign ss = dir_reg ? h_ls : h_rs;
    assign sc = dir_reg ? h_lc : h_rc;
    assign ts = dir_reg ? h_rs : h_ls;
    assign tc = dir_reg ? h_rc : h_lc;

    assign send_raw = {1'b0, ss} + {1'b0, sc};
    assign tend_raw = {1'b0, ts} + {1'b0, tc};
    assign send     = send_raw[LB] ? LINE_MAX : send_raw[LB-1:0];
    assign tend     = tend_raw[LB] ? LINE_MAX : tend_raw[LB-1:0];
    assign below_start = (line_reg < ss);
    assign in_range    = (sc != '0) && (line_reg < send);
    assign last_hunk = ((CNT_W'(idx_reg) + CNT_W'(1)) == total_reg);

    assign diff = line_reg - ss_reg;
    assign lim  = tc_reg - LB'(1);
    assign rel  = (tc_reg == '0) ? '0 : ((diff > lim) ? lim : diff);

    assign sum = {2'b00, base_reg} + {addend_reg[LB], addend_reg};

    assign pop   = (state_reg == S_IDLE) && head_valid;
    assign raddr = (state_reg == S_WALK) ? (idx_reg + IDX_W'(1)) : '0;

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        line_next   = line_reg;
        dir_next    = dir_reg;
        offset_next = offset_reg;
        base_next   = base_reg;
        addend_next = addend_reg;
        ss_next     = ss_reg;
        tc_next     = tc_reg;
        mapped_next = mapped_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    mapped_next = '0;
                    status_next = dhlm_pkg::ST_OK;
                    unique case (head.op)
                        dhlm_pkg::OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (total_reg == CNT_W'(MAX_HUNKS))
                            begin
                                status_next = dhlm_pkg::ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                total_next = total_reg + CNT_W'(1);
                            end
                        end
                        dhlm_pkg::OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            total_next = '0;
                        end
                        dhlm_pkg::OP_QUERY:
                        begin
                            line_next   = LB'(head.source_line);
                            dir_next    = head.left_to_right;
                            offset_next = '0;
                            idx_next    = '0;
                            if (total_reg == '0)
                            begin
                                base_next   = LB'(head.source_line);
                                addend_next = '0;
                                state_next  = S_SUM;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (below_start)
                begin
                    base_next   = line_reg;
                    addend_next = offset_reg;
                    state_next  = S_SUM;
                end
                else if (in_range)
                begin
                    ss_next    = ss;
                    tc_next    = tc;
                    base_next  = ts;
                    state_next = S_REL;
                end
                else
                begin
                    offset_next = {1'b0, tend} - {1'b0, send};
                    if (last_hunk)
                    begin
                        base_next   = line_reg;
                        addend_next = {1'b0, tend} - {1'b0, send};
                        state_next  = S_SUM;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_REL:
            begin
                addend_next = {1'b0, rel};
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (sum[LB+1])
                begin
                    mapped_next = '0;
                    status_next = dhlm_pkg::ST_OK;
                end
                else if (sum[LB])
                begin
                    mapped_next = dhlm_pkg::OUT_W'(LINE_MAX);
                    status_next = dhlm_pkg::ST_SAT;
                end
                else
                begin
                    mapped_next = dhlm_pkg::OUT_W'(sum[LB-1:0]);
                    status_next = dhlm_pkg::ST_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            line_reg   <= '0;
            dir_reg    <= 1'b0;
            offset_reg <= '0;
            base_reg   <= '0;
            addend_reg <= '0;
            ss_reg     <= '0;
            tc_reg     <= '0;
            mapped_reg <= '0;
            status_reg <= dhlm_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            done_reg   <= done_next;
            line_reg   <= line_next;
            dir_reg    <= dir_next;
            offset_reg <= offset_next;
            base_reg   <= base_next;
            addend_reg <= addend_next;
            ss_reg     <= ss_next;
            tc_reg     <= tc_next;
            mapped_reg <= mapped_next;
            status_reg <= status_next;
        end
    end

    assign mapped_line = mapped_reg;
    assign status      = status_reg;
    assign done        = done_reg;

endmodule

### rtl/diff_hunk_line_mapper_unit.sv
// Diff hunk line mapper.
// Command channel: a word (opcode and fields) is taken at a rising edge with
// start high and busy low. Append stores a hunk, clear empties the table,
// query maps source_line to the other side in the direction left_to_right.
// Result channel: done pulses for one cycle with mapped_line and status;
// every command word gives exactly one result, in command order. There is
// no hold-off on the result side: the receiver must take it in that cycle.
// A two-word queue sits between the command decoder and the executor, so
// busy only rises when two words wait behind the one being executed.
// Append, clear and unused opcodes are handled by the executor in its idle
// state, in which it takes the word. A query walks the stored hunks one per
// cycle through the hunk RAM's registered read port and stops at the first
// hunk at or past the line, or at the last hunk, then forms the result in
// S_SUM, passing through S_REL first when the line falls inside that hunk.
// Reset empties the queue and the hunk table; hunk RAM contents are not
// cleared, as entries past the stored count are never used.
module diff_hunk_line_mapper_unit #(
    parameter int MAX_HUNKS = dhlm_pkg::MAX_HUNKS_DEF,
    parameter int LINE_BITS = dhlm_pkg::LINE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [dhlm_pkg::FIELD_W-1:0]  left_start,
    input  logic [dhlm_pkg::FIELD_W-1:0]  left_count,
    input  logic [dhlm_pkg::FIELD_W-1:0]  right_start,
    input  logic [dhlm_pkg::FIELD_W-1:0]  right_count,
    input  logic [dhlm_pkg::FIELD_W-1:0]  source_line,
    input  logic                          left_to_right,
    output logic                          done,
    output logic [dhlm_pkg::OUT_W-1:0]    mapped_line,
    output logic [1:0]                    status
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    logic            head_valid;
    logic            pop;
    dhlm_pkg::item_t head;

    dhlm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .left_start    (left_start),
        .left_count    (left_count),
        .right_start   (right_start),
        .right_count   (right_count),
        .source_line   (source_line),
        .left_to_right (left_to_right),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop)
    );

    dhlm_back #(
        .MAX_HUNKS (MAX_HUNKS),
        .LINE_BITS (LINE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .mapped_line (mapped_line),
        .status      (status),
        .done        (done)
    );

    // queue only fills up through an accepted word
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted word");

    // dropped append carries no line
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == dhlm_pkg::ST_FULL) |-> (mapped_line == '0))
        else $error("table-full result with nonzero line");

    // saturated query reports the line maximum
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == dhlm_pkg::ST_SAT)
            |-> (mapped_line == dhlm_pkg::OUT_W'(LINE_MAX)))
        else $error("saturated result not at line maximum");

    // a full queue always has a word at its head
    a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> head_valid)
        else $error("busy without a queued word");

endmodule
